>>> design/prt_pkg.sv
package prt_pkg;

  // Hybrid token layout: direct range of 2**SymExp values, SymMsb mantissa
  // bits carried in the token, SymLsb low bits carried in the token.
  localparam int unsigned SymExp = 5;
  localparam int unsigned SymMsb = 2;
  localparam int unsigned SymLsb = 0;

  localparam int unsigned SmpW   = 12;
  localparam int unsigned TokW   = 6;
  localparam int unsigned CntW   = 4;
  localparam int unsigned ExtraW = 10;
  localparam int unsigned ModeW  = 4;

  typedef enum logic {
    CmdEncode = 1'b0,
    CmdDecode = 1'b1
  } cmd_e;

  typedef enum logic [ModeW-1:0] {
    PredZero     = 4'd0,
    PredW        = 4'd1,
    PredAvgWNw   = 4'd2,
    PredNw       = 4'd3,
    PredAvgNwN   = 4'd4,
    PredN        = 4'd5,
    PredAvgNNe   = 4'd6,
    PredNe       = 4'd7,
    PredGradient = 4'd8,
    PredAvgNW    = 4'd9,
    PredWeighted = 4'd10
  } pred_mode_e;

  typedef struct packed {
    cmd_e                     command;
    logic signed [SmpW-1:0]   nbr_nw;
    logic signed [SmpW-1:0]   nbr_n;
    logic signed [SmpW-1:0]   nbr_ne;
    logic signed [SmpW-1:0]   nbr_w;
    logic signed [SmpW-1:0]   sample;
    logic        [TokW-1:0]   in_token;
    logic        [ExtraW-1:0] in_extra;
  } in_item_t;

  typedef struct packed {
    logic        [TokW-1:0]   token;
    logic        [CntW-1:0]   extra_count;
    logic        [ExtraW-1:0] extra_bits;
    logic signed [SmpW-1:0]   value;
  } out_item_t;

endpackage

>>> design/prediction_residual_tokenizer_core.sv
// Prediction residual tokenizer. Each transfer on the input channel carries
// one sample with its NW, N, NE and W neighbours and an encode or decode
// command; each yields exactly one result transfer, in order. The block
// accepts one item per cycle unless the output stalls: the item is captured
// in an input register, prediction, residual packing and token split or
// reconstruction run as one combinational pass, and the result is held in
// an output register. A stalled output backs up through both registers to
// in_ready_o. The predictor mode register is written through cfg_we_i/
// cfg_wdata_i and must only change while no item is in flight; modes 11
// to 15 predict zero.
module prediction_residual_tokenizer_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  prt_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output prt_pkg::out_item_t                  out_data_o,
  input  logic                                cfg_we_i,
  input  logic [prt_pkg::ModeW-1:0]           cfg_wdata_i
);

  localparam int unsigned PackW = 13;

  function automatic logic signed [prt_pkg::SmpW-1:0] clamp_smp(
    input logic signed [16:0] x
  );
    logic signed [16:0] lo;
    logic signed [16:0] hi;
    lo = -17'sd2048;
    hi = 17'sd2047;
    if (x < lo) begin
      return lo[prt_pkg::SmpW-1:0];
    end else if (x > hi) begin
      return hi[prt_pkg::SmpW-1:0];
    end
    return x[prt_pkg::SmpW-1:0];
  endfunction

  logic [prt_pkg::ModeW-1:0] mode_q;
  logic                      s1_valid_q, s1_valid_d;
  prt_pkg::in_item_t         s1_data_q;
  logic                      out_valid_q, out_valid_d;
  prt_pkg::out_item_t        out_data_q, out_data_d;
  logic                      s1_ready;

  assign s1_ready    = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || s1_ready;
  assign s1_valid_d  = in_ready_o ? in_valid_i : s1_valid_q;
  assign out_valid_d = s1_ready ? s1_valid_q : out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
    if (s1_valid_q && s1_ready) begin
      out_data_q <= out_data_d;
    end
  end

  // Prediction.
  logic signed [16:0] nw, n, ne, w;
  logic signed [16:0] sum_wnw, sum_nwn, sum_nne, sum_nw;
  logic signed [16:0] grad, med_lo, med_hi, med, wsum, pred_raw;
  logic signed [prt_pkg::SmpW-1:0] pred;

  assign nw = 17'(s1_data_q.nbr_nw);
  assign n  = 17'(s1_data_q.nbr_n);
  assign ne = 17'(s1_data_q.nbr_ne);
  assign w  = 17'(s1_data_q.nbr_w);

  assign sum_wnw = w + nw;
  assign sum_nwn = nw + n;
  assign sum_nne = n + ne;
  assign sum_nw  = n + w;
  assign grad    = sum_nw - nw;
  assign med_lo  = (n < w) ? n : w;
  assign med_hi  = (n < w) ? w : n;
  assign med     = (grad < med_lo) ? med_lo : ((grad > med_hi) ? med_hi : grad);
  assign wsum    = (sum_nw <<< 2) + ne - nw;

  always_comb begin
    case (mode_q)
      prt_pkg::PredW:        pred_raw = w;
      prt_pkg::PredAvgWNw:   pred_raw = sum_wnw >>> 1;
      prt_pkg::PredNw:       pred_raw = nw;
      prt_pkg::PredAvgNwN:   pred_raw = sum_nwn >>> 1;
      prt_pkg::PredN:        pred_raw = n;
      prt_pkg::PredAvgNNe:   pred_raw = sum_nne >>> 1;
      prt_pkg::PredNe:       pred_raw = ne;
      prt_pkg::PredGradient: pred_raw = med;
      prt_pkg::PredAvgNW:    pred_raw = sum_nw >>> 1;
      prt_pkg::PredWeighted: pred_raw = wsum >>> 3;
      default:               pred_raw = '0;
    endcase
  end

  assign pred = clamp_smp(pred_raw);

  // Encode: zigzag packing and hybrid token split.
  logic signed [PackW-1:0] enc_res;
  logic        [PackW:0]   enc_zz;
  logic        [PackW-1:0] enc_packed;
  logic        [3:0]       enc_lg;
  logic        [3:0]       enc_cnt;
  logic        [PackW-1:0] enc_top;
  logic        [prt_pkg::TokW-1:0]   enc_tok;
  logic        [prt_pkg::ExtraW-1:0] enc_bits;

  assign enc_res    = PackW'(s1_data_q.sample) - PackW'(pred);
  assign enc_zz     = {enc_res, 1'b0} ^ {(PackW + 1){enc_res[PackW-1]}};
  assign enc_packed = enc_zz[PackW-1:0];

  always_comb begin
    enc_lg = '0;
    for (int i = 1; i < PackW; i++) begin
      if (enc_packed[i]) begin
        enc_lg = 4'(i);
      end
    end
  end

  // The mantissa bits just below the leading one go into the token.
  assign enc_cnt = enc_lg - 4'(prt_pkg::SymMsb + prt_pkg::SymLsb);
  assign enc_top = enc_packed >> enc_cnt;

  always_comb begin
    if (enc_packed < PackW'(1 << prt_pkg::SymExp)) begin
      enc_tok  = enc_packed[prt_pkg::TokW-1:0];
      enc_bits = '0;
    end else begin
      enc_tok  = 6'(1 << prt_pkg::SymExp)
               + {enc_lg[3:0] - 4'(prt_pkg::SymExp), enc_top[prt_pkg::SymMsb-1:0]};
      enc_bits = enc_packed[prt_pkg::ExtraW-1:0]
               & ~({prt_pkg::ExtraW{1'b1}} << enc_cnt);
    end
  end

  // Decode: rebuild the packed residual and add the prediction.
  logic [prt_pkg::TokW-1:0]   dec_tok;
  logic [prt_pkg::CntW-1:0]   dec_cnt;
  logic [prt_pkg::ExtraW-1:0] dec_bits;
  logic [PackW-1:0]           dec_packed;
  logic [PackW-2:0]           dec_half;
  logic signed [PackW-1:0]    dec_res;
  logic signed [16:0]         dec_sum;

  assign dec_tok = s1_data_q.in_token;

  always_comb begin
    if (dec_tok >= 6'(1 << prt_pkg::SymExp)) begin
      dec_cnt    = {1'b0, dec_tok[4:2]} + 4'(prt_pkg::SymExp - prt_pkg::SymMsb);
      dec_bits   = s1_data_q.in_extra & ~({prt_pkg::ExtraW{1'b1}} << dec_cnt);
      dec_packed = (PackW'({1'b1, dec_tok[1:0]}) << dec_cnt) | PackW'(dec_bits);
    end else begin
      dec_cnt    = '0;
      dec_bits   = '0;
      dec_packed = PackW'(dec_tok);
    end
  end

  assign dec_half = dec_packed[PackW-1:1];
  assign dec_res  = dec_packed[0] ? ~{1'b0, dec_half} : {1'b0, dec_half};
  assign dec_sum  = 17'(dec_res) + 17'(pred);

  always_comb begin
    if (s1_data_q.command == prt_pkg::CmdDecode) begin
      out_data_d.token       = dec_tok;
      out_data_d.extra_count = dec_cnt;
      out_data_d.extra_bits  = dec_bits;
      out_data_d.value       = clamp_smp(dec_sum);
    end else begin
      out_data_d.token       = enc_tok;
      out_data_d.extra_count = (enc_packed < PackW'(1 << prt_pkg::SymExp)) ? '0 : enc_cnt;
      out_data_d.extra_bits  = enc_bits;
      out_data_d.value       = pred;
    end
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int WatchdogLimit = 2000;

  logic                        clk_i;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  prt_pkg::in_item_t           in_data_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  prt_pkg::out_item_t          out_data_o;
  logic                        cfg_we_i = 1'b0;
  logic [prt_pkg::ModeW-1:0]   cfg_wdata_i = '0;

  prt_pkg::in_item_t           pending_pixels[$];
  prt_pkg::out_item_t          expected_tokens[$];
  logic [prt_pkg::ModeW-1:0]   mode_shadow = prt_pkg::PredZero;
  int                          src_gap = 0;
  int                          snk_gap = 0;
  int                          src_idle_pct = 0;
  int                          snk_idle_pct = 0;
  int                          stall_cycles = 0;
  int                          errors = 0;

  prediction_residual_tokenizer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int clamp_sample(int x);
    if (x < -2048) return -2048;
    if (x > 2047) return 2047;
    return x;
  endfunction

  function automatic int calc_prediction(int nw, int n, int ne, int w,
                                         logic [prt_pkg::ModeW-1:0] mode);
    int p;
    int lo;
    int hi;
    int grad;
    case (mode)
      prt_pkg::PredW:        p = w;
      prt_pkg::PredAvgWNw:   p = (w + nw) >>> 1;
      prt_pkg::PredNw:       p = nw;
      prt_pkg::PredAvgNwN:   p = (nw + n) >>> 1;
      prt_pkg::PredN:        p = n;
      prt_pkg::PredAvgNNe:   p = (n + ne) >>> 1;
      prt_pkg::PredNe:       p = ne;
      prt_pkg::PredGradient: begin
        lo   = (n < w) ? n : w;
        hi   = (n < w) ? w : n;
        grad = n + w - nw;
        p    = (grad < lo) ? lo : ((grad > hi) ? hi : grad);
      end
      prt_pkg::PredAvgNW:    p = (n + w) >>> 1;
      prt_pkg::PredWeighted: p = (4 * (n + w) + ne - nw) >>> 3;
      default:               p = 0;
    endcase
    return clamp_sample(p);
  endfunction

  function automatic prt_pkg::out_item_t tokenize_pixel(prt_pkg::in_item_t it,
                                                        logic [prt_pkg::ModeW-1:0] mode);
    prt_pkg::out_item_t r;
    int exp_w;
    int msb_w;
    int lsb_w;
    int pred;
    int res;
    int packed_res;
    int lg;
    int mant;
    int tok;
    int cnt;
    int bits;
    int e;
    int msb;
    int half;
    exp_w = prt_pkg::SymExp;
    msb_w = prt_pkg::SymMsb;
    lsb_w = prt_pkg::SymLsb;
    cnt   = 0;
    bits  = 0;
    pred  = calc_prediction(int'(it.nbr_nw), int'(it.nbr_n), int'(it.nbr_ne),
                            int'(it.nbr_w), mode);
    if (it.command == prt_pkg::CmdEncode) begin
      res        = int'(it.sample) - pred;
      packed_res = (res >= 0) ? 2 * res : -2 * res - 1;
      if (packed_res < (1 << exp_w)) begin
        tok = packed_res;
      end else begin
        lg = 0;
        while ((packed_res >> (lg + 1)) != 0) lg++;
        mant = packed_res - (1 << lg);
        tok  = (1 << exp_w) + (((lg - exp_w) << (msb_w + lsb_w))
               | ((mant >> (lg - msb_w)) << lsb_w));
        cnt  = lg - (msb_w + lsb_w);
        bits = (packed_res >> lsb_w) & ((1 << cnt) - 1);
      end
      r.value = 12'(pred);
    end else begin
      tok = int'(it.in_token);
      e   = tok;
      if (e >= (1 << exp_w)) begin
        e    = e - (1 << exp_w);
        msb  = e & ((1 << msb_w) - 1);
        e    = e >> msb_w;
        cnt  = e + exp_w - (msb_w + lsb_w);
        bits = int'(it.in_extra) & ((1 << cnt) - 1);
        e    = ((((1 << msb_w) | msb) << cnt) | bits);
      end
      half    = e >> 1;
      res     = (e & 1) ? -half - 1 : half;
      r.value = 12'(clamp_sample(res + pred));
    end
    r.token       = 6'(tok);
    r.extra_count = 4'(cnt);
    r.extra_bits  = 10'(bits);
    return r;
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(0, 9))
      0:       return -2048;
      1:       return 2047;
      default: return int'($urandom_range(0, 4095)) - 2048;
    endcase
  endfunction

  // Offsets spread over all magnitudes so that every token class is hit.
  function automatic int rand_offset(int max_log);
    int mag;
    mag = $urandom_range(0, (1 << $urandom_range(0, max_log)) - 1);
    return ($urandom_range(0, 1) == 1) ? -mag : mag;
  endfunction

  function automatic prt_pkg::in_item_t make_random_pixel(logic [prt_pkg::ModeW-1:0] mode);
    prt_pkg::in_item_t it;
    int base;
    int pred;
    it.command = ($urandom_range(0, 1) == 1) ? prt_pkg::CmdDecode : prt_pkg::CmdEncode;
    if ($urandom_range(0, 9) < 6) begin
      // Smooth neighborhood, as in a natural image.
      base      = rand_sample();
      it.nbr_nw = 12'(clamp_sample(base + rand_offset(6)));
      it.nbr_n  = 12'(clamp_sample(base + rand_offset(6)));
      it.nbr_ne = 12'(clamp_sample(base + rand_offset(6)));
      it.nbr_w  = 12'(clamp_sample(base + rand_offset(6)));
    end else begin
      it.nbr_nw = 12'(rand_sample());
      it.nbr_n  = 12'(rand_sample());
      it.nbr_ne = 12'(rand_sample());
      it.nbr_w  = 12'(rand_sample());
    end
    it.sample   = 12'(rand_sample());
    it.in_token = 6'($urandom_range(0, 63));
    it.in_extra = 10'($urandom_range(0, 1023));
    pred = calc_prediction(int'(it.nbr_nw), int'(it.nbr_n), int'(it.nbr_ne),
                           int'(it.nbr_w), mode);
    if (it.command == prt_pkg::CmdEncode && $urandom_range(0, 3) != 0) begin
      it.sample = 12'(clamp_sample(pred + rand_offset(12)));
    end
    return it;
  endfunction

  task automatic add_pixel(prt_pkg::cmd_e cmd, int nw, int n, int ne, int w, int smp,
                           int tok, int extra);
    prt_pkg::in_item_t it;
    it.command  = cmd;
    it.nbr_nw   = 12'(nw);
    it.nbr_n    = 12'(n);
    it.nbr_ne   = 12'(ne);
    it.nbr_w    = 12'(w);
    it.sample   = 12'(smp);
    it.in_token = 6'(tok);
    it.in_extra = 10'(extra);
    pending_pixels.push_back(it);
  endtask

  // Checked at the falling edge so that all transfers of the cycle are done.
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_pixels.size() != 0 || in_valid_i || expected_tokens.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_mode(logic [prt_pkg::ModeW-1:0] mode);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mode_shadow = mode;
  endtask

  task automatic pick_idling();
    int pcts[3] = '{0, 10, 35};
    src_idle_pct = pcts[$urandom_range(0, 2)];
    snk_idle_pct = pcts[$urandom_range(0, 2)];
  endtask

  // Driver: a new pixel goes out once the previous one has been transferred.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_tokens.push_back(tokenize_pixel(in_data_i, mode_shadow));
      end
      if (!in_valid_i || in_ready_o) begin
        if (src_gap > 0) begin
          src_gap    <= src_gap - 1;
          in_valid_i <= 1'b0;
        end else if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
          src_gap    <= $urandom_range(0, 8);
          in_valid_i <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          in_data_i  <= pending_pixels.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    prt_pkg::out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_tokens.size() == 0) begin
          $error("result with no expectation: token %0d value %0d",
                 out_data_o.token, out_data_o.value);
          errors++;
        end else begin
          want = expected_tokens.pop_front();
          if (out_data_o.token !== want.token) begin
            $error("token: expected %0d, actual %0d", want.token, out_data_o.token);
            errors++;
          end
          if (out_data_o.extra_count !== want.extra_count) begin
            $error("extra_count: expected %0d, actual %0d",
                   want.extra_count, out_data_o.extra_count);
            errors++;
          end
          if (out_data_o.extra_bits !== want.extra_bits) begin
            $error("extra_bits: expected %0d, actual %0d",
                   want.extra_bits, out_data_o.extra_bits);
            errors++;
          end
          if (out_data_o.value !== want.value) begin
            $error("value: expected %0d, actual %0d", want.value, out_data_o.value);
            errors++;
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap     <= snk_gap - 1;
        out_ready_i <= 1'b0;
      end else if (snk_idle_pct > 0 && $urandom_range(0, 99) < snk_idle_pct) begin
        snk_gap     <= $urandom_range(0, 8);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero predictor: short token boundary, sample extremes, decode of
    // token classes.
    write_mode(prt_pkg::PredZero);
    add_pixel(prt_pkg::CmdEncode, 0, 0, 0, 0, 0, 63, 1023);
    add_pixel(prt_pkg::CmdEncode, 0, 0, 0, 0, 15, 0, 0);
    add_pixel(prt_pkg::CmdEncode, 0, 0, 0, 0, -16, 0, 0);
    add_pixel(prt_pkg::CmdEncode, 0, 0, 0, 0, 16, 0, 0);
    add_pixel(prt_pkg::CmdEncode, -2048, 2047, -2048, 2047, 2047, 0, 0);
    add_pixel(prt_pkg::CmdEncode, 2047, -2048, 2047, -2048, -2048, 0, 0);
    add_pixel(prt_pkg::CmdDecode, 0, 0, 0, 0, 0, 0, 1023);
    add_pixel(prt_pkg::CmdDecode, 0, 0, 0, 0, 0, 31, 1023);
    add_pixel(prt_pkg::CmdDecode, 0, 0, 0, 0, 0, 32, 1023);
    add_pixel(prt_pkg::CmdDecode, 0, 0, 0, 0, 0, 63, 0);
    wait_drained();

    // Weighted predictor: overshoot on both sides, decode saturation.
    write_mode(prt_pkg::PredWeighted);
    add_pixel(prt_pkg::CmdEncode, -2048, 2047, 2047, 2047, -2048, 0, 0);
    add_pixel(prt_pkg::CmdEncode, 2047, -2048, -2048, -2048, 2047, 0, 0);
    add_pixel(prt_pkg::CmdDecode, -2048, 2047, 2047, 2047, 0, 63, 1023);
    add_pixel(prt_pkg::CmdDecode, -2048, 2047, 2047, 2047, 0, 63, 1022);
    add_pixel(prt_pkg::CmdDecode, 2047, -2048, -2048, -2048, 0, 63, 1023);
    add_pixel(prt_pkg::CmdDecode, 2047, -2048, -2048, -2048, 0, 62, 1022);
    wait_drained();

    // Gradient predictor: each of the three median outcomes.
    write_mode(prt_pkg::PredGradient);
    add_pixel(prt_pkg::CmdEncode, 100, 50, 0, 60, 0, 0, 0);
    add_pixel(prt_pkg::CmdEncode, 10, 50, 0, 60, 0, 0, 0);
    add_pixel(prt_pkg::CmdEncode, 55, 50, 0, 60, 57, 0, 0);
    add_pixel(prt_pkg::CmdDecode, -2048, 2047, 0, 2047, 0, 47, 600);
    wait_drained();

    // Every register value, including the unused modes.
    for (int m = 0; m < 16; m++) begin
      write_mode(4'(m));
      pick_idling();
      for (int i = 0; i < 70; i++) begin
        pending_pixels.push_back(make_random_pixel(mode_shadow));
        // Hold the sender once until everything already sent has come back.
        if (m == 3 && i == 35) wait_drained();
      end
      wait_drained();
    end

    write_mode(4'($urandom_range(0, 15)));
    src_idle_pct = 0;
    snk_idle_pct = 0;
    for (int i = 0; i < 150; i++) begin
      pending_pixels.push_back(make_random_pixel(mode_shadow));
    end
    wait_drained();

    if (expected_tokens.size() != 0) errors++;
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
